@@ src/tqsb_pkg.sv @@
// Package for the two-queue shared buffer: codes, defaults, state and result types.
package tqsb_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int IDX_OUT_W      = 5;
    localparam int IO_DATA_W      = 32;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic SEL_FIRST  = 1'b0;
    localparam logic SEL_SECOND = 1'b1;

    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_DELETED  = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SHIFT,
        ST_DRAIN,
        ST_PLACE
    } t_state;

    typedef struct packed {
        logic                 fin;
        logic                 deq;
        logic [1:0]           status;
        logic [IDX_OUT_W-1:0] front;
        logic [IDX_OUT_W-1:0] rear;
        logic [IDX_OUT_W-1:0] count;
    } t_result;

endpackage

@@ src/tqsb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tqsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

@@ src/tqsb_ctrl.sv @@
// Queue pointer registers and sequencer for the shared buffer, including the downward shift.
module tqsb_ctrl #(
    parameter int DEPTH      = tqsb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tqsb_pkg::DATA_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_operation,
    input  logic                              i_queue_select,
    input  logic [tqsb_pkg::IO_DATA_W-1:0]    i_data_in,
    input  logic [DATA_WIDTH-1:0]             i_rd_data,
    output logic [$clog2(DEPTH)-1:0]          o_rd_addr,
    output logic                              o_wr_en,
    output logic [$clog2(DEPTH)-1:0]          o_wr_addr,
    output logic [DATA_WIDTH-1:0]             o_wr_data,
    output tqsb_pkg::t_result                 o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = AW + 1;
    localparam int XW = DATA_WIDTH + tqsb_pkg::IO_DATA_W;
    localparam int OW = tqsb_pkg::IDX_OUT_W;

    localparam logic [AW-1:0] ONE_A    = AW'(1);
    localparam logic [AW-1:0] TOP_IDX  = AW'(DEPTH - 1);
    localparam logic [AW-1:0] BASE_RST = AW'(DEPTH / 2);
    localparam logic [SW-1:0] SPAN_ONE = SW'(1);
    localparam logic [SW-1:0] SPAN_NEW = SW'(2);

    function automatic logic [AW-1:0] q_count(input logic [AW-1:0] fr,
                                              input logic [AW-1:0] rr,
                                              input logic [SW-1:0] sp);
        logic [SW-1:0] d;
        logic [SW-1:0] w;
        d = {1'b0, rr} - {1'b0, fr};
        w = d + sp;
        if (sp == '0) begin
            return '0;
        end
        if (rr >= fr) begin
            return d[AW-1:0];
        end
        return w[AW-1:0];
    endfunction

    function automatic logic [OW-1:0] to_out(input logic [AW-1:0] v);
        logic [AW+OW-1:0] x;
        x = {{OW{1'b0}}, v};
        return x[OW-1:0];
    endfunction

    tqsb_pkg::t_state r_state, n_state;
    logic             r_op, n_op;
    logic             r_sel, n_sel;
    logic [tqsb_pkg::IO_DATA_W-1:0] r_data, n_data;

    logic [AW-1:0] r_f_rear, n_f_rear, r_f_front, n_f_front, r_f_last, n_f_last;
    logic [SW-1:0] r_f_span, n_f_span;
    logic [AW-1:0] r_s_base, n_s_base, r_s_front, n_s_front;
    logic [AW-1:0] r_s_rear, n_s_rear, r_s_last, n_s_last;
    logic [SW-1:0] r_s_span, n_s_span;

    logic [AW-1:0] r_ptr, n_ptr, r_wa, n_wa;
    logic          r_pend, n_pend;

    logic [XW-1:0]         data_ext;
    logic [DATA_WIDTH-1:0] data_st;
    logic [AW-1:0]         f_nr, f_nf, s_nr, s_nf, s_front_m1;
    logic                  room_below;
    logic                  place_now;
    logic                  fin, deq;
    logic [1:0]            status;
    logic [AW-1:0]         v_front, v_rear;
    logic [SW-1:0]         v_span;

    assign data_ext   = {{DATA_WIDTH{1'b0}}, r_data};
    assign data_st    = data_ext[DATA_WIDTH-1:0];
    assign f_nr       = (r_f_rear == r_f_last) ? '0 : r_f_rear + ONE_A;
    assign f_nf       = (r_f_front == r_f_last) ? '0 : r_f_front + ONE_A;
    assign s_nr       = (r_s_rear == r_s_last) ? r_s_base : r_s_rear + ONE_A;
    assign s_nf       = (r_s_front == r_s_last) ? r_s_base : r_s_front + ONE_A;
    assign s_front_m1 = r_s_front - ONE_A;
    assign room_below = (r_s_base != '0) && (r_s_base - ONE_A != r_f_last);
    assign o_busy     = (r_state != tqsb_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tqsb_pkg::ST_IDLE;
            r_pend    <= 1'b0;
            r_f_rear  <= '0;
            r_f_front <= '0;
            r_f_last  <= '0;
            r_f_span  <= '0;
            r_s_base  <= BASE_RST;
            r_s_front <= BASE_RST;
            r_s_rear  <= BASE_RST;
            r_s_last  <= BASE_RST;
            r_s_span  <= '0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_f_rear  <= n_f_rear;
            r_f_front <= n_f_front;
            r_f_last  <= n_f_last;
            r_f_span  <= n_f_span;
            r_s_base  <= n_s_base;
            r_s_front <= n_s_front;
            r_s_rear  <= n_s_rear;
            r_s_last  <= n_s_last;
            r_s_span  <= n_s_span;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_sel  <= n_sel;
        r_data <= n_data;
        r_ptr  <= n_ptr;
        r_wa   <= n_wa;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_sel     = r_sel;
        n_data    = r_data;
        n_f_rear  = r_f_rear;
        n_f_front = r_f_front;
        n_f_last  = r_f_last;
        n_f_span  = r_f_span;
        n_s_base  = r_s_base;
        n_s_front = r_s_front;
        n_s_rear  = r_s_rear;
        n_s_last  = r_s_last;
        n_s_span  = r_s_span;
        n_ptr     = r_ptr;
        n_wa      = r_wa;
        n_pend    = r_pend;
        o_rd_addr = r_ptr;
        o_wr_en   = 1'b0;
        o_wr_addr = r_wa;
        o_wr_data = data_st;
        place_now = 1'b0;
        fin       = 1'b0;
        deq       = 1'b0;
        status    = tqsb_pkg::STAT_INSERTED;

        unique case (r_state)
            tqsb_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_op    = i_operation;
                    n_sel   = i_queue_select;
                    n_data  = i_data_in;
                    n_state = tqsb_pkg::ST_EXEC;
                end
            end
            tqsb_pkg::ST_EXEC: begin
                n_state = tqsb_pkg::ST_IDLE;
                fin     = 1'b1;
                if (r_sel == tqsb_pkg::SEL_FIRST && r_op == tqsb_pkg::OP_ENQ) begin
                    if (r_f_span == '0) begin
                        if (r_s_base > ONE_A) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_f_rear + ONE_A;
                            n_f_rear  = r_f_rear + ONE_A;
                            n_f_last  = r_f_last + ONE_A;
                            n_f_span  = SPAN_NEW;
                        end else begin
                            status = tqsb_pkg::STAT_FULL;
                        end
                    end else if (f_nr == r_f_front) begin
                        if (r_f_rear == r_f_last && r_f_last + ONE_A != r_s_base) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_f_last + ONE_A;
                            n_f_rear  = r_f_last + ONE_A;
                            n_f_last  = r_f_last + ONE_A;
                            n_f_span  = r_f_span + SPAN_ONE;
                        end else begin
                            status = tqsb_pkg::STAT_FULL;
                        end
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = f_nr;
                        n_f_rear  = f_nr;
                    end
                end else if (r_sel == tqsb_pkg::SEL_FIRST) begin
                    if (r_f_span == '0 || r_f_front == r_f_rear) begin
                        status = tqsb_pkg::STAT_EMPTY;
                    end else begin
                        fin       = 1'b0;
                        n_state   = tqsb_pkg::ST_READ;
                        o_rd_addr = f_nf;
                        n_f_front = f_nf;
                        if (f_nf == r_f_rear) begin
                            n_f_rear  = '0;
                            n_f_front = '0;
                            n_f_last  = '0;
                            n_f_span  = '0;
                        end
                    end
                end else if (r_op == tqsb_pkg::OP_ENQ) begin
                    if (r_s_span == '0) begin
                        if (r_s_base < TOP_IDX) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_s_base + ONE_A;
                            n_s_front = r_s_base;
                            n_s_rear  = r_s_base + ONE_A;
                            n_s_last  = r_s_base + ONE_A;
                            n_s_span  = SPAN_NEW;
                        end else begin
                            status = tqsb_pkg::STAT_FULL;
                        end
                    end else if (s_nr != r_s_front) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = s_nr;
                        n_s_rear  = s_nr;
                    end else if (r_s_rear == r_s_last && r_s_last < TOP_IDX) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_s_last + ONE_A;
                        n_s_rear  = r_s_last + ONE_A;
                        n_s_last  = r_s_last + ONE_A;
                        n_s_span  = r_s_span + SPAN_ONE;
                    end else if (!room_below || r_s_front == '0) begin
                        status = tqsb_pkg::STAT_FULL;
                    end else if (r_s_rear != r_s_last) begin
                        fin     = 1'b0;
                        n_state = tqsb_pkg::ST_SHIFT;
                        n_ptr   = r_s_base;
                        n_pend  = 1'b0;
                    end else begin
                        place_now = 1'b1;
                    end
                end else begin
                    if (r_s_span == '0 || r_s_rear == r_s_front) begin
                        status = tqsb_pkg::STAT_EMPTY;
                    end else begin
                        fin       = 1'b0;
                        n_state   = tqsb_pkg::ST_READ;
                        o_rd_addr = s_nf;
                        n_s_front = s_nf;
                        if (s_nf == r_s_rear) begin
                            n_s_base  = r_s_base + ONE_A;
                            n_s_front = r_s_base + ONE_A;
                            n_s_rear  = r_s_base + ONE_A;
                            n_s_last  = r_s_base + ONE_A;
                            n_s_span  = '0;
                        end
                    end
                end
            end
            tqsb_pkg::ST_READ: begin
                fin     = 1'b1;
                deq     = 1'b1;
                status  = tqsb_pkg::STAT_DELETED;
                n_state = tqsb_pkg::ST_IDLE;
            end
            tqsb_pkg::ST_SHIFT: begin
                // read entry at r_ptr, write the one read last cycle one slot lower
                o_rd_addr = r_ptr;
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_wa;
                    o_wr_data = i_rd_data;
                end
                n_wa   = r_ptr - ONE_A;
                n_pend = 1'b1;
                n_ptr  = r_ptr + ONE_A;
                if (r_ptr == s_front_m1) begin
                    n_state = tqsb_pkg::ST_DRAIN;
                end
            end
            tqsb_pkg::ST_DRAIN: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_wa;
                o_wr_data = i_rd_data;
                n_pend    = 1'b0;
                n_state   = tqsb_pkg::ST_PLACE;
            end
            tqsb_pkg::ST_PLACE: begin
                place_now = 1'b1;
                fin       = 1'b1;
                n_state   = tqsb_pkg::ST_IDLE;
            end
        endcase

        if (place_now) begin
            o_wr_en   = 1'b1;
            o_wr_addr = s_front_m1;
            o_wr_data = data_st;
            n_s_span  = r_s_span + SPAN_ONE;
            n_s_rear  = s_front_m1;
            n_s_base  = r_s_base - ONE_A;
        end
    end

    assign v_front = (r_sel == tqsb_pkg::SEL_SECOND) ? n_s_front : n_f_front;
    assign v_rear  = (r_sel == tqsb_pkg::SEL_SECOND) ? n_s_rear : n_f_rear;
    assign v_span  = (r_sel == tqsb_pkg::SEL_SECOND) ? n_s_span : n_f_span;

    assign o_result.fin    = fin;
    assign o_result.deq    = deq;
    assign o_result.status = status;
    assign o_result.front  = to_out(v_front);
    assign o_result.rear   = to_out(v_rear);
    assign o_result.count  = to_out(q_count(v_front, v_rear, v_span));

    a_shift_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tqsb_pkg::ST_SHIFT && o_wr_en) |-> (o_wr_addr != o_rd_addr))
        else $error("shift writes the address it reads");

    a_first_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_span != '0) |-> (r_f_span == {1'b0, r_f_last} + SPAN_ONE))
        else $error("first queue span does not match its region");

    a_second_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_span != '0) |-> (r_s_span == {1'b0, r_s_last} - {1'b0, r_s_base} + SPAN_ONE))
        else $error("second queue span does not match its region");

    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.fin |=> (r_state == tqsb_pkg::ST_IDLE))
        else $error("sequencer not idle after a result");

endmodule

@@ src/two_queue_shared_buffer_core.sv @@
// Top level of the two-queue shared buffer: sequencer, word RAM and result registers.
// Enqueue without shift and full/empty results: busy only in EXEC, strobe registered after EXEC.
// Dequeue: EXEC then READ (one registered RAM read of the new front), strobe registered after.
// Enqueue that shifts the second queue down: SHIFT, DRAIN, PLACE; one RAM word per cycle.
// A new item may be accepted in the cycle the strobe is shown. Reset is synchronous and
// restores both queues to empty; the word RAM is not cleared.
module two_queue_shared_buffer_core #(
    parameter int DEPTH      = tqsb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tqsb_pkg::DATA_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic                                     i_operation,
    input  logic                                     i_queue_select,
    input  logic signed [tqsb_pkg::IO_DATA_W-1:0]    i_data_in,
    output logic                                     o_done,
    output logic [1:0]                               o_status,
    output logic signed [tqsb_pkg::IO_DATA_W-1:0]    o_data_out,
    output logic [tqsb_pkg::IDX_OUT_W-1:0]           o_front_index,
    output logic [tqsb_pkg::IDX_OUT_W-1:0]           o_rear_index,
    output logic [tqsb_pkg::IDX_OUT_W-1:0]           o_item_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int XW = DATA_WIDTH + tqsb_pkg::IO_DATA_W;

    logic [AW-1:0]         rd_addr, wr_addr;
    logic                  wr_en;
    logic [DATA_WIDTH-1:0] wr_data, rd_data;
    logic [XW-1:0]         rd_ext;
    tqsb_pkg::t_result     res;

    logic                                r_done;
    logic [1:0]                          r_status;
    logic [tqsb_pkg::IO_DATA_W-1:0]      r_data_out;
    logic [tqsb_pkg::IDX_OUT_W-1:0]      r_front, r_rear, r_count;

    tqsb_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_operation    (i_operation),
        .i_queue_select (i_queue_select),
        .i_data_in      (i_data_in),
        .i_rd_data      (rd_data),
        .o_rd_addr      (rd_addr),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_result       (res)
    );

    tqsb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_ext = {{tqsb_pkg::IO_DATA_W{1'b0}}, rd_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= res.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.fin) begin
            r_status   <= res.status;
            r_data_out <= res.deq ? rd_ext[tqsb_pkg::IO_DATA_W-1:0] : '0;
            r_front    <= res.front;
            r_rear     <= res.rear;
            r_count    <= res.count;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_data_out    = r_data_out;
    assign o_front_index = r_front;
    assign o_rear_index  = r_rear;
    assign o_item_count  = r_count;

endmodule
